>>> sv/rclfp_pkg.sv
`timescale 1ns / 1ps
package rclfp_pkg;

   typedef enum logic [3:0] {
      PH_SYNC,
      PH_LENGTH,
      PH_TYPE,
      PH_PAYLOAD,
      PH_CRC,
      PH_CRC_CALC,
      PH_RD_ADDR,
      PH_RD_DATA,
      PH_F_PRIME,
      PH_F_DIFF,
      PH_F_MUL,
      PH_F_ACC,
      PH_OUT
   } phase_type;

   localparam logic [2:0] CSR_SYNC_BYTE       = 3'd0;
   localparam logic [2:0] CSR_MIN_LENGTH      = 3'd1;
   localparam logic [2:0] CSR_MAX_LENGTH      = 3'd2;
   localparam logic [2:0] CSR_CHANNELS_TYPE   = 3'd3;
   localparam logic [2:0] CSR_LINK_STATS_TYPE = 3'd4;
   localparam logic [2:0] CSR_FILTER_GAIN     = 3'd5;

   localparam logic [7:0]  CRC_POLY         = 8'hD5;
   localparam logic [4:0]  PAYLOAD_CH_BYTES = 5'd22;
   localparam logic [10:0] CH_MIN           = 11'd172;
   localparam logic [10:0] CH_MAX           = 11'd1811;
   localparam logic [3:0]  LAST_CHANNEL     = 4'd15;
   localparam logic [3:0]  LAST_STAT        = 4'd9;
   localparam logic [0:0]  KIND_CHANNEL     = 1'b0;
   localparam logic [0:0]  KIND_STAT        = 1'b1;

   function automatic logic [10:0] clamp_round(input logic [26:0] y);
      logic [27:0] r;
      r = {1'b0, y} + 28'd32768;
      if (y < {CH_MIN, 16'd0}) return CH_MIN;
      if (y > {CH_MAX, 16'd0}) return CH_MAX;
      return r[26:16];
   endfunction

endpackage

>>> sv/rc_link_frame_parser_stick_lowpass_top.sv
`timescale 1ns / 1ps
// Byte transactions: sync, length and CRC bytes are taken directly; type and
// payload bytes run a bit-serial CRC-8, one bit per cycle, with req_ready low.
// Results: a channel takes three registered store reads, a filtered one then
// difference, multiply and accumulate steps, or one priming step on the priming
// frame; a statistics byte takes one registered store read. Stalls hold the output.
// Reset (synchronous, active high) restores register defaults, clears store valid
// bits, filter state and handshakes.
module rc_link_frame_parser_stick_lowpass_top import rclfp_pkg::*; #(
   parameter int STORE_DEPTH       = 64,
   parameter int FILTERED_CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_record_kind,
   output logic [3:0]  rsp_field_index,
   output logic [10:0] rsp_field_value,
   output logic        rsp_last_of_frame,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW  = $clog2(STORE_DEPTH);
   localparam int WPW = $clog2(STORE_DEPTH + 1);
   localparam int NF  = (FILTERED_CHANNELS > 0) ? FILTERED_CHANNELS : 1;
   localparam int FW  = (NF > 1) ? $clog2(NF) : 1;

   logic [7:0]  sync_ff, chtype_ff, lstype_ff;
   logic [6:0]  minl_ff, maxl_ff;
   logic [15:0] gain_ff;

   phase_type   phase_ff, phase_in, ret_ff, ret_in;
   logic [6:0]  bl_ff, bl_in;
   logic [7:0]  ftype_ff, ftype_in;
   logic [WPW-1:0] wp_ff, wp_in;
   logic [7:0]  crc_ff, crc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [7:0]  mem_ff [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] vld_ff;
   logic        wr_en;
   logic [AW-1:0] wr_idx, rd_idx;
   logic [7:0]  rdata_ff;
   logic        rhit_ff, rd_hit;
   logic [4:0]  rd_addr;
   logic [3:0]  ch_ff, ch_in;
   logic        stat_ff, stat_in;
   logic [1:0]  fc_ff, fc_in;
   logic [23:0] acc_ff, acc_in;
   logic [26:0] y_ff [NF];
   logic [26:0] y_new;
   logic        y_we;
   logic        primed_ff, primed_in;
   logic signed [27:0] d_ff, d_in;
   logic signed [44:0] prod_ff, prod_in, sum;
   logic [FW-1:0] fidx;
   logic        filt;
   logic [7:0]  bitpos;
   logic [23:0] shifted;
   logic [10:0] raw, val;
   logic        last, out_free, len_bad, crc_ok;
   logic [6:0]  bl_dec;

   logic        rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [3:0]  rsp_index_ff;
   logic [10:0] rsp_value_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= 8'd200;
         minl_ff   <= 7'd2;
         maxl_ff   <= 7'd62;
         chtype_ff <= 8'd22;
         lstype_ff <= 8'd20;
         gain_ff   <= 16'd26214;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_BYTE:       sync_ff   <= csr_wdata[7:0];
            CSR_MIN_LENGTH:      minl_ff   <= csr_wdata[6:0];
            CSR_MAX_LENGTH:      maxl_ff   <= csr_wdata[6:0];
            CSR_CHANNELS_TYPE:   chtype_ff <= csr_wdata[7:0];
            CSR_LINK_STATS_TYPE: lstype_ff <= csr_wdata[7:0];
            CSR_FILTER_GAIN:     gain_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign len_bad  = (req_rx_byte < 8'd2) || (req_rx_byte < {1'b0, minl_ff}) ||
                     (req_rx_byte > {1'b0, maxl_ff});
   assign crc_ok   = (req_rx_byte == crc_ff) &&
                     ((ftype_ff == chtype_ff) || (ftype_ff == lstype_ff));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last     = stat_ff ? (ch_ff == LAST_STAT) : (ch_ff == LAST_CHANNEL);
   assign filt     = !stat_ff && ({1'b0, ch_ff} < 5'(FILTERED_CHANNELS));
   assign fidx     = FW'(ch_ff);
   assign bl_dec   = bl_ff - 7'd1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_SYNC:     if (req_valid && req_rx_byte == sync_ff) phase_in = PH_LENGTH;
         PH_LENGTH:   if (req_valid) phase_in = len_bad ? PH_SYNC : PH_TYPE;
         PH_TYPE:     if (req_valid) phase_in = PH_CRC_CALC;
         PH_PAYLOAD:  if (req_valid) phase_in = PH_CRC_CALC;
         PH_CRC_CALC: if (cnt_ff == 3'd7) phase_in = ret_ff;
         PH_CRC:      if (req_valid) phase_in = crc_ok ? PH_RD_ADDR : PH_SYNC;
         PH_RD_ADDR:  phase_in = PH_RD_DATA;
         PH_RD_DATA: begin
            if (stat_ff) phase_in = PH_OUT;
            else if (fc_ff != 2'd2) phase_in = PH_RD_ADDR;
            else if (!filt) phase_in = PH_OUT;
            else phase_in = primed_ff ? PH_F_DIFF : PH_F_PRIME;
         end
         PH_F_PRIME:  phase_in = PH_OUT;
         PH_F_DIFF:   phase_in = PH_F_MUL;
         PH_F_MUL:    phase_in = PH_F_ACC;
         PH_F_ACC:    phase_in = PH_OUT;
         PH_OUT:      if (out_free) phase_in = last ? PH_SYNC : PH_RD_ADDR;
         default:     phase_in = PH_SYNC;
      endcase
   end

   // datapath
   always_comb begin
      req_ready = (phase_ff inside {PH_SYNC, PH_LENGTH, PH_TYPE, PH_PAYLOAD, PH_CRC});
      ret_in    = ret_ff;
      bl_in     = bl_ff;
      ftype_in  = ftype_ff;
      wp_in     = wp_ff;
      crc_in    = crc_ff;
      cnt_in    = cnt_ff;
      wr_en     = 1'b0;
      ch_in     = ch_ff;
      stat_in   = stat_ff;
      fc_in     = fc_ff;
      acc_in    = acc_ff;
      primed_in = primed_ff;
      d_in      = d_ff;
      prod_in   = prod_ff;
      y_we      = 1'b0;
      y_new     = y_ff[fidx];
      bitpos    = {1'b0, ch_ff, 3'd0} + {3'd0, ch_ff, 1'b0} + {4'd0, ch_ff};
      rd_addr   = stat_ff ? {1'b0, ch_ff} : bitpos[7:3] + {3'd0, fc_ff};
      shifted   = acc_ff >> bitpos[2:0];
      raw       = stat_ff ? {3'd0, acc_ff[23:16]} : shifted[10:0];
      val       = filt ? clamp_round(y_ff[fidx]) : raw;
      sum       = prod_ff + 45'sd32768;
      unique case (phase_ff)
         PH_LENGTH: bl_in = req_rx_byte[6:0];
         PH_TYPE: begin
            if (req_valid) begin
               ftype_in = req_rx_byte;
               bl_in    = bl_dec;
               wp_in    = '0;
               crc_in   = req_rx_byte;
               cnt_in   = '0;
               ret_in   = (bl_dec <= 7'd1) ? PH_CRC : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (req_valid) begin
               wr_en  = (wp_ff < WPW'(STORE_DEPTH));
               if (wr_en) wp_in = wp_ff + 1'b1;
               crc_in = crc_ff ^ req_rx_byte;
               bl_in  = bl_dec;
               cnt_in = '0;
               ret_in = (bl_dec <= 7'd1) ? PH_CRC : PH_PAYLOAD;
            end
         end
         PH_CRC_CALC: begin
            crc_in = crc_ff[7] ? ({crc_ff[6:0], 1'b0} ^ CRC_POLY) : {crc_ff[6:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         PH_CRC: begin
            ch_in   = '0;
            fc_in   = '0;
            stat_in = (ftype_ff != chtype_ff);
         end
         PH_RD_DATA: begin
            acc_in = {rhit_ff ? rdata_ff : 8'd0, acc_ff[23:8]};
            fc_in  = fc_ff + 1'b1;
         end
         PH_F_PRIME: begin
            y_we  = 1'b1;
            y_new = {raw, 16'd0};
         end
         PH_F_DIFF: d_in = $signed({1'b0, raw, 16'd0}) - $signed({1'b0, y_ff[fidx]});
         PH_F_MUL:  prod_in = $signed({1'b0, gain_ff}) * d_ff;
         PH_F_ACC: begin
            y_we  = 1'b1;
            y_new = 27'($signed({18'd0, y_ff[fidx]}) + (sum >>> 16));
         end
         PH_OUT: begin
            if (out_free) begin
               ch_in = ch_ff + 1'b1;
               fc_in = '0;
               if (last && !stat_ff) primed_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign wr_idx = AW'(wp_ff);
   assign rd_idx = AW'(rd_addr);
   assign rd_hit = stat_ff || (rd_addr < PAYLOAD_CH_BYTES);

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_idx] <= req_rx_byte;
      rdata_ff <= mem_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rhit_ff <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_idx] <= 1'b1;
         rhit_ff <= rd_hit && vld_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NF; i++) y_ff[i] <= '0;
      end else if (y_we) begin
         y_ff[fidx] <= y_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC;
         ret_ff       <= PH_SYNC;
         bl_ff        <= '0;
         ftype_ff     <= '0;
         wp_ff        <= '0;
         crc_ff       <= '0;
         cnt_ff       <= '0;
         ch_ff        <= '0;
         stat_ff      <= 1'b0;
         fc_ff        <= '0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         ret_ff    <= ret_in;
         bl_ff     <= bl_in;
         ftype_ff  <= ftype_in;
         wp_ff     <= wp_in;
         crc_ff    <= crc_in;
         cnt_ff    <= cnt_in;
         ch_ff     <= ch_in;
         stat_ff   <= stat_in;
         fc_ff     <= fc_in;
         primed_ff <= primed_in;
         if (phase_ff == PH_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      d_ff    <= d_in;
      prod_ff <= prod_in;
      if (phase_ff == PH_OUT && out_free) begin
         rsp_kind_ff  <= stat_ff ? KIND_STAT : KIND_CHANNEL;
         rsp_index_ff <= ch_ff;
         rsp_value_ff <= val;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_record_kind   = rsp_kind_ff;
   assign rsp_field_index   = rsp_index_ff;
   assign rsp_field_value   = rsp_value_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

>>> sv/rclfp_checker.sv
`timescale 1ns / 1ps
module rclfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_record_kind,
   input logic [3:0]  rsp_field_index,
   input logic [10:0] rsp_field_value,
   input logic        rsp_last_of_frame
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_value) &&
      $stable(rsp_field_index) && $stable(rsp_record_kind))
      else $error("rsp transaction changed while stalled");

   a_reset_idle: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |->
      (!rsp_record_kind && rsp_field_index == 4'd15) ||
      (rsp_record_kind && rsp_field_index == 4'd9))
      else $error("last flag on wrong field");

   a_stat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_kind |-> rsp_field_index <= 4'd9 &&
      rsp_field_value[10:8] == 3'd0)
      else $error("statistics transaction out of range");

endmodule

bind rc_link_frame_parser_stick_lowpass_top rclfp_checker u_rclfp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_record_kind   (rsp_record_kind),
   .rsp_field_index   (rsp_field_index),
   .rsp_field_value   (rsp_field_value),
   .rsp_last_of_frame (rsp_last_of_frame)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import rclfp_pkg::*;

   typedef struct packed {
      logic        kind;
      logic [3:0]  idx;
      logic [10:0] val;
      logic        last;
   } field_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_record_kind;
   logic [3:0]  rsp_field_index;
   logic [10:0] rsp_field_value;
   logic        rsp_last_of_frame;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [15:0] csr_wdata = 16'd0;

   rc_link_frame_parser_stick_lowpass_top dut (.*);

   initial forever #6 clock = ~clock;

   // predictor state
   logic [7:0]  cfg_sync, cfg_chan_type, cfg_stat_type;
   logic [6:0]  cfg_min_len, cfg_max_len;
   logic [15:0] cfg_gain;
   phase_type   prs_phase;
   logic [7:0]  prs_left, prs_kind, prs_crc;
   logic [7:0]  prs_store [64];
   int          prs_wptr;
   logic [26:0] stick_acc [4];
   logic        stick_primed;

   field_rec_type expected_fields [$];
   int          errors = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;

   function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++)
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic logic [10:0] pick_channel(input int ch);
      int          bitpos;
      int          bi;
      logic [23:0] w;
      bitpos = 11 * ch;
      bi = bitpos / 8;
      w = 24'd0;
      for (int k = 0; k < 3; k++)
         if (bi + k < 22) w[8*k +: 8] = prs_store[bi + k];
      return 11'(w >> (bitpos % 8));
   endfunction

   function automatic logic [10:0] round_clamp(input logic [26:0] y);
      if (y < {CH_MIN, 16'd0}) return CH_MIN;
      if (y > {CH_MAX, 16'd0}) return CH_MAX;
      return 11'((28'(y) + 28'd32768) >> 16);
   endfunction

   task automatic predictor_reset();
      cfg_sync = 8'd200; cfg_min_len = 7'd2; cfg_max_len = 7'd62;
      cfg_chan_type = 8'd22; cfg_stat_type = 8'd20; cfg_gain = 16'd26214;
      prs_phase = PH_SYNC; prs_left = 0; prs_kind = 0; prs_crc = 0; prs_wptr = 0;
      foreach (prs_store[i]) prs_store[i] = 8'd0;
      foreach (stick_acc[i]) stick_acc[i] = 27'd0;
      stick_primed = 1'b0;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      field_rec_type r;
      logic [10:0] v;
      longint d, p;
      case (prs_phase)
         PH_SYNC: if (b == cfg_sync) prs_phase = PH_LENGTH;
         PH_LENGTH: begin
            if (b < 2 || b < cfg_min_len || b > cfg_max_len) prs_phase = PH_SYNC;
            else begin
               prs_left = b;
               prs_phase = PH_TYPE;
            end
         end
         PH_TYPE: begin
            prs_kind = b;
            prs_left = prs_left - 1;
            prs_wptr = 0;
            prs_crc = crc8_d5(8'd0, b);
            prs_phase = (prs_left <= 1) ? PH_CRC : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (prs_wptr < 64) begin
               prs_store[prs_wptr] = b;
               prs_wptr++;
            end
            prs_crc = crc8_d5(prs_crc, b);
            prs_left = prs_left - 1;
            if (prs_left <= 1) prs_phase = PH_CRC;
         end
         PH_CRC: begin
            prs_phase = PH_SYNC;
            if (b == prs_crc) begin
               if (prs_kind == cfg_chan_type) begin
                  for (int i = 0; i < 16; i++) begin
                     v = pick_channel(i);
                     if (i < 4) begin
                        if (!stick_primed) stick_acc[i] = {v, 16'd0};
                        else begin
                           d = longint'({v, 16'd0}) - longint'(stick_acc[i]);
                           p = longint'(cfg_gain) * d + 32768;
                           stick_acc[i] = 27'(longint'(stick_acc[i]) + (p >>> 16));
                        end
                        v = round_clamp(stick_acc[i]);
                     end
                     r = '{KIND_CHANNEL, 4'(i), v, i == 15};
                     expected_fields.push_back(r);
                  end
                  stick_primed = 1'b1;
               end else if (prs_kind == cfg_stat_type) begin
                  for (int i = 0; i < 10; i++) begin
                     r = '{KIND_STAT, 4'(i), {3'd0, prs_store[i]}, i == 9};
                     expected_fields.push_back(r);
                  end
               end
            end
         end
         default: prs_phase = PH_SYNC;
      endcase
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fields.size() == 0) begin
            $error("unexpected result transaction");
            errors++;
         end else begin
            field_rec_type e;
            e = expected_fields.pop_front();
            if (rsp_record_kind !== e.kind) begin
               $error("record_kind exp %0d got %0d", e.kind, rsp_record_kind); errors++;
            end
            if (rsp_field_index !== e.idx) begin
               $error("field_index exp %0d got %0d", e.idx, rsp_field_index); errors++;
            end
            if (rsp_field_value !== e.val) begin
               $error("field_value exp %0d got %0d", e.val, rsp_field_value); errors++;
            end
            if (rsp_last_of_frame !== e.last) begin
               $error("last_of_frame exp %0d got %0d", e.last, rsp_last_of_frame); errors++;
            end
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_byte(b);
      gap = 0;
      if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SYNC_BYTE:       cfg_sync = val[7:0];
         CSR_MIN_LENGTH:      cfg_min_len = val[6:0];
         CSR_MAX_LENGTH:      cfg_max_len = val[6:0];
         CSR_CHANNELS_TYPE:   cfg_chan_type = val[7:0];
         CSR_LINK_STATS_TYPE: cfg_stat_type = val[7:0];
         CSR_FILTER_GAIN:     cfg_gain = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // frame: sync, length, type, payload, crc (optionally corrupted)
   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] body [],
                             input logic bad_crc = 1'b0, input int len_adj = 0);
      logic [7:0] c;
      c = crc8_d5(8'd0, ftype);
      foreach (body[i]) c = crc8_d5(c, body[i]);
      send_byte(cfg_sync);
      send_byte(8'(body.size() + 2 + len_adj));
      send_byte(ftype);
      foreach (body[i]) send_byte(body[i]);
      send_byte(bad_crc ? ~c : c);
   endtask

   task automatic send_channels(input logic [10:0] fill, input logic rnd,
                                input logic bad_crc = 1'b0);
      logic [7:0] body [];
      logic [175:0] bits;
      for (int i = 0; i < 16; i++)
         bits[11*i +: 11] = rnd ? 11'($urandom) : fill;
      body = new[22];
      foreach (body[i]) body[i] = bits[8*i +: 8];
      send_frame(cfg_chan_type, body, bad_crc);
   endtask

   task automatic send_random_body(input logic [7:0] ftype, input int n,
                                   input logic bad_crc = 1'b0);
      logic [7:0] body [];
      body = new[n];
      foreach (body[i]) body[i] = 8'($urandom);
      send_frame(ftype, body, bad_crc);
   endtask

   task automatic test_directed();
      logic [7:0] none [];
      none = new[0];
      send_byte(8'h00); send_byte(8'hFF);
      send_channels(11'd0, 1'b0);
      send_channels(11'h7FF, 1'b0);
      send_random_body(cfg_stat_type, 10);
      send_random_body(cfg_stat_type, 10, 1'b1);
      send_random_body(8'h55, 4);
      send_frame(cfg_chan_type, none);
      send_byte(cfg_sync); send_byte(8'd1); send_byte(8'd0);
      send_byte(cfg_sync); send_byte(8'd63); send_byte(8'd5);
      send_random_body(cfg_chan_type, 3);
      send_random_body(cfg_stat_type, 2);
      wait_drain();
   endtask

   task automatic test_registers();
      write_reg(CSR_SYNC_BYTE, 16'h00FF);
      write_reg(CSR_MIN_LENGTH, 16'd5);
      write_reg(CSR_MAX_LENGTH, 16'd4);
      write_reg(3'd6, 16'hFFFF);
      write_reg(3'd7, 16'h0000);
      send_random_body(cfg_stat_type, 10);
      wait_drain();
      write_reg(CSR_SYNC_BYTE, 16'h0000);
      write_reg(CSR_MIN_LENGTH, 16'd24);
      write_reg(CSR_MAX_LENGTH, 16'd24);
      write_reg(CSR_CHANNELS_TYPE, 16'h00FF);
      write_reg(CSR_LINK_STATS_TYPE, 16'h00FF);
      write_reg(CSR_FILTER_GAIN, 16'hFFFF);
      send_channels(11'd0, 1'b1);
      wait_drain();
      write_reg(CSR_MIN_LENGTH, 16'd2);
      write_reg(CSR_MAX_LENGTH, 16'd24);
      write_reg(CSR_CHANNELS_TYPE, 16'h0000);
      write_reg(CSR_LINK_STATS_TYPE, 16'h0001);
      write_reg(CSR_FILTER_GAIN, 16'h0000);
      send_channels(11'd0, 1'b1);
      send_random_body(8'h01, 12);
      wait_drain();
      write_reg(CSR_SYNC_BYTE, 16'd200);
      write_reg(CSR_MAX_LENGTH, 16'd62);
      write_reg(CSR_CHANNELS_TYPE, 16'd22);
      write_reg(CSR_LINK_STATS_TYPE, 16'd20);
      write_reg(CSR_FILTER_GAIN, 16'd26214);
   endtask

   task automatic test_random(input int idle, input int stall, input int nbytes);
      int start;
      idle_pct = idle;
      stall_pct = stall;
      start = 0;
      while (start < nbytes) begin
         int sel;
         sel = $urandom_range(99);
         if (sel < 45) begin
            send_channels(11'd0, 1'b1, $urandom_range(9) == 0); start += 26;
         end else if (sel < 70) begin
            send_random_body(cfg_stat_type, $urandom_range(10, 14), $urandom_range(9) == 0);
            start += 16;
         end else if (sel < 80) begin
            send_random_body(8'($urandom), $urandom_range(0, 8)); start += 8;
         end else begin
            repeat (4) send_byte(8'($urandom));
            start += 4;
         end
      end
      wait_drain();
   endtask

   initial begin
      predictor_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_registers();
      test_random(0, 0, 12);
      test_random(62, 0, 12);
      test_random(0, 62, 12);
      test_random(19, 19, 12);
      if (errors == 0) $display("testbench: done, clean");
      else $display("testbench: done, errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench: done, errors");
      $finish;
   end
endmodule
